// ===== rtl/lbk_pkg.sv =====
`timescale 1ns / 1ps

package lbk_pkg;

  // Width of the running sum of squared excess and of its root
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned ROOT_W = 32;

  // Row position counter saturates here
  localparam int unsigned POS_W   = 16;
  localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;

  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [ROOT_W-1:0] root_t;

endpackage

// ===== rtl/multivariate_lb_keogh_bound_core.sv =====
`timescale 1ns / 1ps

// Streaming LB_Keogh lower bound over multivariate series. Each item carries one query and
// one candidate sample of a dimension row; tlast ends a row, tuser ends the series and a
// result (root of the saturating sum of squared envelope excess, plus a saturation flag)
// follows. Query and candidate history sit in two single-port-read RAMs. An item is taken
// only while idle; every position that becomes due is then scored by scanning the query ring
// one entry per cycle over its clipped envelope of w entries (at most 2r+1), then taking the
// distance, square and sum. A normal item scores one position once r later samples
// have arrived; a row end scores the up to r pending positions; a series end runs the
// bit-serial square root and loads the result register, held while an earlier one still
// waits. The radius is sampled at the first item of each row and clamped to MAX_RADIUS.
module multivariate_lb_keogh_bound_core #(
  parameter int unsigned MAX_RADIUS   = 64,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // radius register write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,   // window_radius
  // sample pairs
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // q_sample, a_sample, zero pad
  input  logic                                  s_axis_tlast,  // last_in_row
  input  logic                                  s_axis_tuser,  // last_in_series
  // bound result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // bound
  output logic        m_axis_tuser    // saturated
);

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned QD  = 2 * MAX_RADIUS + 1;
  localparam int unsigned AD  = MAX_RADIUS + 1;
  localparam int unsigned QAW = $clog2(QD);
  localparam int unsigned AAW = $clog2(AD);
  localparam int unsigned RW  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned OW  = QAW + 1;
  localparam int unsigned PW  = lbk_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_SCAN, S_DIFF, S_SQ, S_ACC, S_ROOT, S_OUT
  } state_e;

  state_e         state_q, state_d;
  logic [6:0]     radius_q;
  logic [RW-1:0]  row_radius_q, row_radius_d;
  logic [PW-1:0]  row_pos_q, row_pos_d;
  logic [PW-1:0]  count_q, count_d;
  logic [QAW-1:0] qhead_q, qhead_d;
  logic [AAW-1:0] ahead_q, ahead_d;
  logic [RW-1:0]  d_q, d_d;
  logic [RW-1:0]  flush_q, flush_d;
  logic [OW-1:0]  last_q, last_d;
  logic [OW-1:0]  off_q, off_d;
  logic           first_q, first_d;
  logic           series_q, series_d;
  logic [SW-1:0]  lo_q, lo_d, hi_q, hi_d, aval_q, aval_d;
  logic [SW-1:0]  diff_q, diff_d;
  lbk_pkg::acc_t  sq_q, sq_d;
  lbk_pkg::acc_t  sum_q, sum_d;
  logic           ovf_q, ovf_d;
  logic           root_start;
  logic           root_done;
  lbk_pkg::root_t root_val;
  logic           m_valid_q, m_valid_d;
  lbk_pkg::root_t m_data_q, m_data_d;
  logic           m_sat_q, m_sat_d;

  logic           in_acc;
  logic [SW-1:0]  q_in, a_in;
  logic [PW-1:0]  cnt_in;
  logic [RW-1:0]  r_in;
  logic           row_end;
  logic           p_ge_r;
  logic [RW-1:0]  nflush;
  logic [PW-1:0]  cnt_sel;
  logic [RW-1:0]  r_sel;
  logic [RW-1:0]  disp_d;
  logic [PW:0]    span, cnt_m1;
  logic [OW-1:0]  disp_last;
  logic [QAW:0]   q_ext;
  logic [AAW:0]   a_ext;
  logic [QAW-1:0] q_raddr;
  logic [AAW-1:0] a_raddr;
  logic [QAW-1:0] q_waddr;
  logic [AAW-1:0] a_waddr;
  logic [SW-1:0]  q_rdata, a_rdata;
  logic [OW-1:0]  scan_off;
  logic [SW-1:0]  diff_c;
  logic [lbk_pkg::ACC_W:0] sum_ext;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Offset-binary samples so unsigned order matches signed order
  assign q_in    = s_axis_tdata[SW-1:0] ^ {1'b1, {(SW-1){1'b0}}};
  assign a_in    = s_axis_tdata[2*SW-1:SW] ^ {1'b1, {(SW-1){1'b0}}};
  assign row_end = s_axis_tlast | s_axis_tuser;

  // Position bookkeeping for the item at the input
  assign cnt_in = (row_pos_q != lbk_pkg::POS_MAX) ? row_pos_q + 1'b1 : lbk_pkg::POS_MAX;
  always_comb begin
    r_in = row_radius_q;
    if (row_pos_q == '0) begin
      if (32'(radius_q) > MAX_RADIUS) r_in = RW'(MAX_RADIUS);
      else                            r_in = RW'(radius_q);
    end
  end
  assign p_ge_r = row_pos_q >= PW'(r_in);
  assign nflush = p_ge_r ? r_in : RW'(row_pos_q) + 1'b1;

  // Ring write pointers advance before the write
  assign q_waddr = (qhead_q == QAW'(QD - 1)) ? '0 : qhead_q + 1'b1;
  assign a_waddr = (ahead_q == AAW'(AD - 1)) ? '0 : ahead_q + 1'b1;

  // Envelope length of the next scored position
  assign cnt_sel   = (state_q == S_IDLE) ? cnt_in : count_q;
  assign r_sel     = (state_q == S_IDLE) ? r_in : row_radius_q;
  assign disp_d    = (state_q == S_IDLE && p_ge_r) ? r_in : flush_d;
  assign span      = (PW+1)'(disp_d) + (PW+1)'(r_sel);
  assign cnt_m1    = (PW+1)'(cnt_sel) - 1'b1;
  assign disp_last = (span < cnt_m1) ? OW'(span) : OW'(cnt_m1);

  // Ring read addresses: candidate d back, query off back
  assign scan_off = (state_q == S_SCAN) ? off_q : '0;
  always_comb begin
    q_ext = (QAW+1)'(qhead_q) + (QAW+1)'(QD) - (QAW+1)'(scan_off);
    if (q_ext >= (QAW+1)'(QD)) q_ext = q_ext - (QAW+1)'(QD);
    a_ext = (AAW+1)'(ahead_q) + (AAW+1)'(AD) - (AAW+1)'(d_q);
    if (a_ext >= (AAW+1)'(AD)) a_ext = a_ext - (AAW+1)'(AD);
  end
  assign q_raddr = q_ext[QAW-1:0];
  assign a_raddr = a_ext[AAW-1:0];

  lbk_ram #(.WIDTH(SW), .DEPTH(QD)) u_qram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (q_waddr),
    .wdata_i (q_in),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  lbk_ram #(.WIDTH(SW), .DEPTH(AD)) u_aram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (a_waddr),
    .wdata_i (a_in),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  // Root of the sum as it stands after the last accumulation
  lbk_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (sum_d),
    .done_o  (root_done),
    .root_o  (root_val)
  );

  // Distance of the candidate to the envelope
  always_comb begin
    if (aval_q < lo_q)      diff_c = lo_q - aval_q;
    else if (aval_q > hi_q) diff_c = aval_q - hi_q;
    else                    diff_c = '0;
  end
  assign sum_ext = (lbk_pkg::ACC_W+1)'(sum_q) + (lbk_pkg::ACC_W+1)'(sq_q);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    row_radius_d = row_radius_q;
    row_pos_d    = row_pos_q;
    count_d      = count_q;
    qhead_d      = qhead_q;
    ahead_d      = ahead_q;
    d_d          = d_q;
    flush_d      = flush_q;
    last_d       = last_q;
    off_d        = off_q;
    first_d      = first_q;
    series_d     = series_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    aval_d       = aval_q;
    diff_d       = diff_q;
    sq_d         = sq_q;
    sum_d        = sum_q;
    ovf_d        = ovf_q;
    root_start   = 1'b0;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    m_sat_d      = m_sat_q;

    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          row_radius_d = r_in;
          count_d      = cnt_in;
          row_pos_d    = row_end ? '0 : cnt_in;
          qhead_d      = q_waddr;
          ahead_d      = a_waddr;
          series_d     = s_axis_tuser;
          if (p_ge_r) begin
            flush_d = row_end ? nflush : '0;
            d_d     = r_in;
            last_d  = disp_last;
            state_d = S_ISSUE;
          end else if (row_end) begin
            flush_d = nflush - 1'b1;
            d_d     = flush_d;
            last_d  = disp_last;
            state_d = S_ISSUE;
          end else if (s_axis_tuser) begin
            root_start = 1'b1;
            state_d    = S_ROOT;
          end
        end
      end
      S_ISSUE: begin
        off_d   = OW'(1);
        first_d = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // fold the entry read last cycle, issue the next one
        first_d = 1'b0;
        if (first_q) begin
          lo_d   = q_rdata;
          hi_d   = q_rdata;
          aval_d = a_rdata;
        end else begin
          if (q_rdata < lo_q) lo_d = q_rdata;
          if (q_rdata > hi_q) hi_d = q_rdata;
        end
        if (off_q <= last_q) off_d = off_q + 1'b1;
        else                 state_d = S_DIFF;
      end
      S_DIFF: begin
        diff_d  = diff_c;
        state_d = S_SQ;
      end
      S_SQ: begin
        sq_d    = lbk_pkg::ACC_W'(diff_q * diff_q);
        state_d = S_ACC;
      end
      S_ACC: begin
        if (sum_ext[lbk_pkg::ACC_W]) begin
          sum_d = '1;
          ovf_d = 1'b1;
        end else begin
          sum_d = sum_ext[lbk_pkg::ACC_W-1:0];
        end
        if (flush_q != '0) begin
          flush_d = flush_q - 1'b1;
          d_d     = flush_d;
          last_d  = disp_last;
          state_d = S_ISSUE;
        end else if (series_q) begin
          root_start = 1'b1;
          state_d    = S_ROOT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ROOT: begin
        if (root_done) state_d = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = root_val;
          m_sat_d   = ovf_q;
          sum_d     = '0;
          ovf_d     = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      radius_q     <= '0;
      row_radius_q <= '0;
      row_pos_q    <= '0;
      qhead_q      <= '0;
      ahead_q      <= '0;
      flush_q      <= '0;
      series_q     <= 1'b0;
      sum_q        <= '0;
      ovf_q        <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_valid_i) radius_q <= cfg_data_i;
      row_radius_q <= row_radius_d;
      row_pos_q    <= row_pos_d;
      qhead_q      <= qhead_d;
      ahead_q      <= ahead_d;
      flush_q      <= flush_d;
      series_q     <= series_d;
      sum_q        <= sum_d;
      ovf_q        <= ovf_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    d_q      <= d_d;
    last_q   <= last_d;
    off_q    <= off_d;
    first_q  <= first_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    aval_q   <= aval_d;
    diff_q   <= diff_d;
    sq_q     <= sq_d;
    m_data_q <= m_data_d;
    m_sat_q  <= m_sat_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_sat_q;

  // The scan never runs past the clipped envelope
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (off_q <= last_q + 1'b1))
    else $error("envelope scan overran its length");

  // The root finishes only while the sequencer waits for it
  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == S_ROOT))
    else $error("square root finished outside the root phase");

  // The latched row radius stays within the ring size
  a_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_radius_q) <= MAX_RADIUS))
    else $error("row radius above maximum");

  // A finished sum is cleared right after its result is registered
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && state_d == S_IDLE) |=> (sum_q == '0 && !ovf_q))
    else $error("sum not cleared after result");

endmodule

// ===== rtl/lbk_ram.sv =====
`timescale 1ns / 1ps

module lbk_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 129
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lbk_isqrt.sv =====
`timescale 1ns / 1ps

module lbk_isqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lbk_pkg::acc_t value_i,
  output logic          done_o,
  output lbk_pkg::root_t root_o
);

  localparam int unsigned STEPS = lbk_pkg::ACC_W / 2;
  localparam int unsigned CW    = $clog2(STEPS);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  lbk_pkg::acc_t x_q, x_d, res_q, res_d, bit_q, bit_d;
  lbk_pkg::acc_t trial;

  assign trial = res_q + bit_q;

  // One result bit per cycle, restoring digit recurrence
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = value_i;
      res_d  = '0;
      bit_d  = lbk_pkg::acc_t'(1) << (lbk_pkg::ACC_W - 2);
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_d   = x_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[lbk_pkg::ROOT_W-1:0];

endmodule

// ===== bench/lbk_bound_checker.sv =====
`timescale 1ns / 1ps

module lbk_bound_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,    // q_sample, a_sample
  input  logic        s_tlast_i,    // last_in_row
  input  logic        s_tuser_i,    // last_in_series
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,    // bound
  input  logic        m_tuser_i,    // saturated
  output int          fail_count_o,
  output int          pending_o,
  output int          items_o,
  output int          bounds_o
);

  localparam int RMAX  = 64;
  localparam int QLEN  = 2 * RMAX + 1;
  localparam int ALEN  = RMAX + 1;
  localparam int PSAT  = 65535;

  typedef struct packed {
    lbk_pkg::root_t bound;
    logic           saturated;
  } bound_rec_t;

  // predictor state, samples held in offset-binary so unsigned order is signed order
  logic [15:0]   env_ring [QLEN];
  logic [15:0]   cand_ring [ALEN];
  int            env_head, cand_head;
  int            row_pos;
  int            radius_reg, row_radius;
  lbk_pkg::acc_t excess_sum;
  logic          sum_clamped;
  bound_rec_t    bound_queue [$];

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    fail_count_o++;
  endtask

  // add the squared excess of the candidate sample d items back
  task automatic score_position(int d, int cnt);
    logic [15:0] a, lo, hi, v, diff;
    logic [64:0] wide;
    int          last;
    a    = cand_ring[(cand_head + ALEN - d) % ALEN];
    last = d + row_radius;
    if (last > cnt - 1) last = cnt - 1;
    lo = env_ring[env_head];
    hi = lo;
    for (int off = 1; off <= last; off++) begin
      v = env_ring[(env_head + QLEN - off) % QLEN];
      if (v < lo) lo = v;
      if (v > hi) hi = v;
    end
    if (a < lo) diff = lo - a;
    else if (a > hi) diff = a - hi;
    else return;
    wide = {1'b0, excess_sum} + 65'(32'(diff) * 32'(diff));
    if (wide[64]) begin
      excess_sum  = '1;
      sum_clamped = 1'b1;
    end else begin
      excess_sum = wide[63:0];
    end
  endtask

  function automatic lbk_pkg::root_t int_root(lbk_pkg::acc_t x);
    lbk_pkg::acc_t res, bit_v;
    res   = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x   = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res[31:0];
  endfunction

  // advance the predictor by one accepted item
  task automatic predict_item(logic [15:0] qs, logic [15:0] as, logic row_end, logic ser_end);
    int p, cnt, d;
    bound_rec_t rec;
    p   = row_pos;
    cnt = (p < PSAT) ? p + 1 : PSAT;
    if (p == 0) row_radius = (radius_reg > RMAX) ? RMAX : radius_reg;
    env_head  = (env_head + 1) % QLEN;
    env_ring[env_head] = {~qs[15], qs[14:0]};
    cand_head = (cand_head + 1) % ALEN;
    cand_ring[cand_head] = {~as[15], as[14:0]};
    if (p >= row_radius) score_position(row_radius, cnt);
    if (row_end || ser_end) begin
      d = (p < row_radius) ? p : row_radius - 1;
      for (; d >= 0; d--) score_position(d, cnt);
      row_pos = 0;
    end else begin
      row_pos = cnt;
    end
    if (ser_end) begin
      rec.bound     = int_root(excess_sum);
      rec.saturated = sum_clamped;
      bound_queue   = {bound_queue, rec};
      pending_o     = bound_queue.size();
      excess_sum  = '0;
      sum_clamped = 1'b0;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    items_o      = 0;
    bounds_o     = 0;
    env_head     = 0;
    cand_head    = 0;
    row_pos      = 0;
    radius_reg   = 0;
    row_radius   = 0;
    excess_sum   = '0;
    sum_clamped  = 1'b0;
  end

  // watch all three channels
  always @(posedge clk_i) begin
    bound_rec_t exp_rec;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) radius_reg = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        items_o++;
        predict_item(s_tdata_i[15:0], s_tdata_i[31:16], s_tlast_i, s_tuser_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        bounds_o++;
        if (bound_queue.size() == 0) begin
          report_mismatch("unexpected result, bound", 0, m_tdata_i);
        end else begin
          exp_rec   = bound_queue.pop_front();
          pending_o = bound_queue.size();
          if (m_tdata_i !== exp_rec.bound)
            report_mismatch("bound", exp_rec.bound, m_tdata_i);
          if (m_tuser_i !== exp_rec.saturated)
            report_mismatch("saturated", exp_rec.saturated, m_tuser_i);
        end
      end
    end
  end

endmodule

// ===== bench/tb_multivariate_lb_keogh_bound_core.sv =====
`timescale 1ns / 1ps

module tb_multivariate_lb_keogh_bound_core;

  localparam int DRAIN     = 10000;
  localparam int LIMIT     = 4000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // q_sample, a_sample
  logic        s_axis_tlast;   // last_in_row
  logic        s_axis_tuser;   // last_in_series
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // bound
  logic        m_axis_tuser;   // saturated

  int  fail_count, pending, items_seen, bounds_seen;
  int  cycles = 0;

  multivariate_lb_keogh_bound_core dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  lbk_bound_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .s_tlast_i(s_axis_tlast), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tuser_i(m_axis_tuser),
    .fail_count_o(fail_count), .pending_o(pending), .items_o(items_seen),
    .bounds_o(bounds_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 11) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // stall the result side in bursts
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if ($urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  // end the run if it hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(logic [15:0] q, logic [15:0] a, logic row_end, logic ser_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {a, q};
    s_axis_tlast  <= row_end;
    s_axis_tuser  <= ser_end;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait for every result, then let the block finish any scoring still under way
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [6:0] r);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // random series: full-range samples, some candidates held close to the query
  task automatic random_series(int n_items);
    int sent, rows, len;
    logic [15:0] q, a;
    sent = 0;
    while (sent < n_items) begin
      rows = $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          q = 16'($urandom);
          a = ($urandom_range(0, 2) == 0) ? q + 16'($urandom_range(0, 64)) - 16'd32
                                         : 16'($urandom);
          if (i == len - 1 && r == rows - 1)
            send_item(q, a, $urandom_range(0, 3) != 0, 1'b1);
          else
            send_item(q, a, i == len - 1, 1'b0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int radii [5];
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // radius zero: extremes, single-item series, series end without row end
    write_radius(7'd0);
    send_item(16'h8000, 16'h7FFF, 1'b0, 1'b0);
    send_item(16'h7FFF, 16'h8000, 1'b0, 1'b0);
    send_item(16'h0000, 16'h0000, 1'b1, 1'b1);
    send_item(16'h8000, 16'h8000, 1'b1, 1'b1);
    send_item(16'h7FFF, 16'h8000, 1'b0, 1'b1);
    settle();

    // small radius over several rows, then change it in the middle of a row
    write_radius(7'd2);
    send_item(16'h0100, 16'h8000, 1'b0, 1'b0);
    send_item(16'hFF00, 16'h0500, 1'b0, 1'b0);
    send_item(16'h0200, 16'h0180, 1'b0, 1'b0);
    send_item(16'h0000, 16'h7FFF, 1'b0, 1'b0);
    send_item(16'h0300, 16'hFE00, 1'b1, 1'b0);
    send_item(16'h1234, 16'h4321, 1'b1, 1'b0);
    send_item(16'h0010, 16'h0020, 1'b0, 1'b0);
    settle();
    write_radius(7'd5);
    send_item(16'h0020, 16'h9000, 1'b0, 1'b0);
    send_item(16'h0030, 16'h0040, 1'b1, 1'b0);
    send_item(16'h0050, 16'h7000, 1'b0, 1'b0);
    send_item(16'h0060, 16'h0000, 1'b1, 1'b1);
    settle();

    // radius above the maximum is clamped; row shorter than the window
    write_radius(7'd127);
    send_item(16'h8000, 16'h7FFF, 1'b0, 1'b0);
    send_item(16'h7FFF, 16'h8000, 1'b0, 1'b0);
    send_item(16'h0000, 16'h8000, 1'b0, 1'b0);
    send_item(16'h0001, 16'h7FFF, 1'b1, 1'b1);
    settle();

    // random phases over a spread of radii
    radii = '{0, 1, 3, 64, 0};
    radii[4] = $urandom_range(4, 20);
    foreach (radii[k]) begin
      write_radius(7'(radii[k]));
      random_series((k == 3) ? 40 : 75);
      settle();
    end

    $display("ran %0d sample items and %0d bounds at radii 0, 1, 2, 3, 5, 64, 127 and %0d",
             items_seen, bounds_seen, radii[4]);
    $display("with extreme samples, a mid-row radius change and series ending mid-row");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
